/* design/tfpaw_pkg.sv */
`timescale 1ns / 1ps
package tfpaw_pkg;

   localparam int MAX_TRIANGLES = 64;
   localparam int FRACTION_BITS = 16;
   localparam int IDX_W = $clog2(MAX_TRIANGLES);
   localparam int CNT_W = $clog2(MAX_TRIANGLES + 1);
   localparam int HIT_W = 6;
   localparam int CRS_W = 68;
   localparam int FRC_W = FRACTION_BITS;
   localparam int DIV_CW = $clog2(FRACTION_BITS + 1);

   localparam logic [1:0] STATUS_LOADED = 2'd0;
   localparam logic [1:0] STATUS_MAPPED = 2'd1;
   localparam logic [1:0] STATUS_PASSED = 2'd2;
   localparam logic [1:0] STATUS_FULL   = 2'd3;

   localparam logic CMD_LOAD      = 1'b0;
   localparam logic CMD_TRANSFORM = 1'b1;

   // One classified item handed from the front end to the back end.
   typedef struct packed {
      logic               transform;
      logic               write_tri;
      logic [1:0]         status;
      logic [IDX_W-1:0]   tri_idx;
      logic [CNT_W-1:0]   tri_count;
      logic signed [31:0] ax;
      logic signed [31:0] ay;
      logic signed [31:0] bx;
      logic signed [31:0] by;
      logic signed [31:0] cx;
      logic signed [31:0] cy;
      logic signed [31:0] adx;
      logic signed [31:0] ady;
      logic signed [31:0] bdx;
      logic signed [31:0] bdy;
      logic signed [31:0] cdx;
      logic signed [31:0] cdy;
   } job_type;

endpackage

/* design/tfpaw_front.sv */
`timescale 1ns / 1ps
module tfpaw_front
   import tfpaw_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_command,
   input  logic               req_polygon_start,
   input  logic signed [31:0] req_src_x,
   input  logic signed [31:0] req_src_y,
   input  logic signed [31:0] req_dst_x,
   input  logic signed [31:0] req_dst_y,
   input  logic signed [31:0] req_point_x,
   input  logic signed [31:0] req_point_y,
   output logic               job_valid,
   input  logic               job_stall,
   output job_type            job
);

   logic signed [31:0] anc_sx_ff, anc_sy_ff, anc_dx_ff, anc_dy_ff;
   logic signed [31:0] prv_sx_ff, prv_sy_ff, prv_dx_ff, prv_dy_ff;
   logic [1:0]         nverts_ff;
   logic [CNT_W-1:0]   count_ff;
   logic               accept;
   logic               new_poly;
   logic               full;

   // The front end is a pure classifier; it stalls only when the queue is full.
   assign req_stall = job_stall;
   assign job_valid = req_valid;
   assign accept    = req_valid && !job_stall;
   assign new_poly  = req_polygon_start || (nverts_ff == 2'd0);
   assign full      = (count_ff == CNT_W'(MAX_TRIANGLES));

   // Build the job that the back end carries out.
   always_comb begin
      job           = '0;
      job.transform = (req_command == CMD_TRANSFORM);
      job.tri_count = count_ff;
      job.tri_idx   = count_ff[IDX_W-1:0];
      job.status    = STATUS_LOADED;
      job.ax  = req_point_x;
      job.ay  = req_point_y;
      if (req_command == CMD_LOAD) begin
         job.ax  = anc_sx_ff;
         job.ay  = anc_sy_ff;
         job.bx  = prv_sx_ff;
         job.by  = prv_sy_ff;
         job.cx  = req_src_x;
         job.cy  = req_src_y;
         job.adx = anc_dx_ff;
         job.ady = anc_dy_ff;
         job.bdx = prv_dx_ff;
         job.bdy = prv_dy_ff;
         job.cdx = req_dst_x;
         job.cdy = req_dst_y;
         if (!new_poly && nverts_ff == 2'd2) begin
            if (full) begin
               job.status = STATUS_FULL;
            end else begin
               job.write_tri = 1'b1;
            end
         end
      end
   end

   // Fan state and triangle count.
   always_ff @(posedge clock) begin
      if (reset) begin
         nverts_ff <= 2'd0;
         count_ff  <= '0;
         anc_sx_ff <= '0; anc_sy_ff <= '0; anc_dx_ff <= '0; anc_dy_ff <= '0;
         prv_sx_ff <= '0; prv_sy_ff <= '0; prv_dx_ff <= '0; prv_dy_ff <= '0;
      end else if (accept && req_command == CMD_LOAD) begin
         prv_sx_ff <= req_src_x;
         prv_sy_ff <= req_src_y;
         prv_dx_ff <= req_dst_x;
         prv_dy_ff <= req_dst_y;
         if (new_poly) begin
            anc_sx_ff <= req_src_x;
            anc_sy_ff <= req_src_y;
            anc_dx_ff <= req_dst_x;
            anc_dy_ff <= req_dst_y;
            nverts_ff <= 2'd1;
         end else begin
            nverts_ff <= 2'd2;
            if (job.write_tri) begin
               count_ff <= count_ff + 1'b1;
            end
         end
      end
   end

endmodule

/* design/tfpaw_queue.sv */
`timescale 1ns / 1ps
module tfpaw_queue
   import tfpaw_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_stall,
   input  job_type in_job,
   output logic    out_valid,
   input  logic    out_stall,
   output job_type out_job
);

   job_type    slot_ff [2];
   logic       wptr_ff, rptr_ff;
   logic [1:0] fill_ff;
   logic       push, pop;

   // Two-entry queue between the front and back ends.
   assign in_stall  = (fill_ff == 2'd2);
   assign out_valid = (fill_ff != 2'd0);
   assign out_job   = slot_ff[rptr_ff];
   assign push      = in_valid && !in_stall;
   assign pop       = out_valid && !out_stall;

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wptr_ff] <= in_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         fill_ff <= 2'd0;
      end else begin
         if (push) wptr_ff <= ~wptr_ff;
         if (pop)  rptr_ff <= ~rptr_ff;
         fill_ff <= fill_ff + {1'b0, push} - {1'b0, pop};
      end
   end

endmodule

/* design/tfpaw_back.sv */
`timescale 1ns / 1ps
module tfpaw_back
   import tfpaw_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               job_valid,
   output logic               job_stall,
   input  job_type            job,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_out_x,
   output logic signed [31:0] rsp_out_y,
   output logic [1:0]         rsp_status,
   output logic [5:0]         rsp_triangle_hit
);

   typedef enum logic [10:0] {
      ST_IDLE  = 11'b00000000001,
      ST_READ  = 11'b00000000010,
      ST_DIFF  = 11'b00000000100,
      ST_MUL   = 11'b00000001000,
      ST_CROSS = 11'b00000010000,
      ST_TEST  = 11'b00000100000,
      ST_DIV   = 11'b00001000000,
      ST_WMUL  = 11'b00010000000,
      ST_WSUM  = 11'b00100000000,
      ST_WADD  = 11'b01000000000,
      ST_OUT   = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;

   // Triangle memories: one row holds three vertices of 64 bits.
   logic [191:0] src_mem [MAX_TRIANGLES];
   logic [191:0] dst_mem [MAX_TRIANGLES];
   logic [191:0] src_rd_ff, dst_rd_ff;

   logic signed [31:0] px_ff, py_ff;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   idx_ff;
   logic signed [32:0] d1x_ff, d1y_ff, d2x_ff, d2y_ff, vx_ff, vy_ff;
   logic signed [65:0] m_ff [6];
   logic signed [CRS_W-1:0] den_ff, ns_ff, nt_ff;
   logic [CRS_W-1:0]   rem_ff;
   logic [FRC_W-1:0]   q_ff, s_ff;
   logic [DIV_CW-1:0]  step_ff;
   logic               second_ff;
   logic signed [32:0] ex1_ff, ex2_ff, ey1_ff, ey2_ff;
   logic signed [FRC_W+33:0] wm_ff [4];
   logic signed [FRC_W+34:0] sx_ff, sy_ff;
   logic signed [31:0] out_x_ff, out_y_ff;
   logic [1:0]         status_ff;
   logic [5:0]         hit_ff;
   logic               rsp_valid_ff;

   logic signed [31:0] s_ax, s_ay, s_bx, s_by, s_cx, s_cy;
   logic signed [31:0] t_ax, t_ay, t_bx, t_by, t_cx, t_cy;
   logic signed [CRS_W-1:0] den_w, ns_w, nt_w;
   logic [CRS_W-1:0]   rem_sh, sum_u;
   logic               contained;
   logic               take;

   assign {s_cy, s_cx, s_by, s_bx, s_ay, s_ax} = src_rd_ff;
   assign {t_cy, t_cx, t_by, t_bx, t_ay, t_ax} = dst_rd_ff;

   assign take      = job_valid && (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign job_stall = !take;

   // Triangle store writes and registered row reads.
   always_ff @(posedge clock) begin
      if (take && job.write_tri) begin
         src_mem[job.tri_idx] <= {job.cy, job.cx, job.by, job.bx, job.ay, job.ax};
         dst_mem[job.tri_idx] <= {job.cdy, job.cdx, job.bdy, job.bdx, job.ady, job.adx};
      end
      src_rd_ff <= src_mem[idx_ff[IDX_W-1:0]];
      dst_rd_ff <= dst_mem[idx_ff[IDX_W-1:0]];
   end

   // Sign-normalized cross products and containment test.
   always_comb begin
      den_w = CRS_W'(m_ff[0]) - CRS_W'(m_ff[1]);
      ns_w  = CRS_W'(m_ff[2]) - CRS_W'(m_ff[3]);
      nt_w  = CRS_W'(m_ff[4]) - CRS_W'(m_ff[5]);
      sum_u = ns_ff + nt_ff;
      contained = (den_ff != '0) && (ns_ff > 0) && (nt_ff > 0) && (sum_u < den_ff);
      rem_sh = {rem_ff[CRS_W-2:0], 1'b0};
   end

   // Next-state logic of the sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (take) state_in = job.transform ? ST_READ : ST_OUT;
         ST_READ:  state_in = (idx_ff == count_ff) ? ST_OUT : ST_DIFF;
         ST_DIFF:  state_in = ST_MUL;
         ST_MUL:   state_in = ST_CROSS;
         ST_CROSS: state_in = ST_TEST;
         ST_TEST:  state_in = contained ? ST_DIV : ST_READ;
         ST_DIV:   if (second_ff && step_ff == DIV_CW'(FRC_W)) state_in = ST_WMUL;
         ST_WMUL:  state_in = ST_WSUM;
         ST_WSUM:  state_in = ST_WADD;
         ST_WADD:  state_in = ST_OUT;
         ST_OUT:   state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_OUT) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Datapath: scan, divide, and blend.
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            if (take) begin
               px_ff     <= job.ax;
               py_ff     <= job.ay;
               count_ff  <= job.tri_count;
               idx_ff    <= '0;
               out_x_ff  <= job.transform ? job.ax : 32'sd0;
               out_y_ff  <= job.transform ? job.ay : 32'sd0;
               status_ff <= job.transform ? STATUS_PASSED : job.status;
               hit_ff    <= '0;
            end
         end
         ST_READ: ;
         ST_DIFF: begin
            d1x_ff <= 33'(s_bx) - 33'(s_ax);
            d1y_ff <= 33'(s_by) - 33'(s_ay);
            d2x_ff <= 33'(s_cx) - 33'(s_ax);
            d2y_ff <= 33'(s_cy) - 33'(s_ay);
            vx_ff  <= 33'(px_ff) - 33'(s_ax);
            vy_ff  <= 33'(py_ff) - 33'(s_ay);
            ex1_ff <= 33'(t_bx) - 33'(t_ax);
            ex2_ff <= 33'(t_cx) - 33'(t_ax);
            ey1_ff <= 33'(t_by) - 33'(t_ay);
            ey2_ff <= 33'(t_cy) - 33'(t_ay);
         end
         ST_MUL: begin
            m_ff[0] <= d2x_ff * d1y_ff;
            m_ff[1] <= d2y_ff * d1x_ff;
            m_ff[2] <= vy_ff * d2x_ff;
            m_ff[3] <= vx_ff * d2y_ff;
            m_ff[4] <= vx_ff * d1y_ff;
            m_ff[5] <= vy_ff * d1x_ff;
         end
         ST_CROSS: begin
            den_ff <= den_w[CRS_W-1] ? -den_w : den_w;
            ns_ff  <= den_w[CRS_W-1] ? -ns_w : ns_w;
            nt_ff  <= den_w[CRS_W-1] ? -nt_w : nt_w;
         end
         ST_TEST: begin
            if (contained) begin
               rem_ff    <= ns_ff;
               q_ff      <= '0;
               step_ff   <= '0;
               second_ff <= 1'b0;
               status_ff <= STATUS_MAPPED;
               hit_ff    <= HIT_W'(idx_ff);
            end else begin
               idx_ff <= idx_ff + 1'b1;
            end
         end
         ST_DIV: begin
            // Restoring division, one quotient bit a cycle. After the first
            // quotient is parked in s_ff, the second one stays in q_ff.
            if (step_ff == DIV_CW'(FRC_W)) begin
               if (!second_ff) begin
                  s_ff      <= q_ff;
                  rem_ff    <= nt_ff;
                  q_ff      <= '0;
                  step_ff   <= '0;
                  second_ff <= 1'b1;
               end
            end else begin
               step_ff <= step_ff + 1'b1;
               if (rem_sh >= den_ff) begin
                  rem_ff <= rem_sh - den_ff;
                  q_ff   <= {q_ff[FRC_W-2:0], 1'b1};
               end else begin
                  rem_ff <= rem_sh;
                  q_ff   <= {q_ff[FRC_W-2:0], 1'b0};
               end
            end
         end
         ST_WMUL: begin
            wm_ff[0] <= ex1_ff * $signed({1'b0, s_ff});
            wm_ff[1] <= ex2_ff * $signed({1'b0, q_ff});
            wm_ff[2] <= ey1_ff * $signed({1'b0, s_ff});
            wm_ff[3] <= ey2_ff * $signed({1'b0, q_ff});
         end
         ST_WSUM: begin
            sx_ff <= (FRC_W+35)'(wm_ff[0]) + (FRC_W+35)'(wm_ff[1]);
            sy_ff <= (FRC_W+35)'(wm_ff[2]) + (FRC_W+35)'(wm_ff[3]);
         end
         ST_WADD: begin
            out_x_ff <= 32'(t_ax + 32'(sx_ff >>> FRC_W));
            out_y_ff <= 32'(t_ay + 32'(sy_ff >>> FRC_W));
         end
         ST_OUT: ;
         default: ;
      endcase
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_x        = out_x_ff;
   assign rsp_out_y        = out_y_ff;
   assign rsp_status       = status_ff;
   assign rsp_triangle_hit = hit_ff;

endmodule

/* design/triangle_fan_piecewise_affine_warp.sv */
`timescale 1ns / 1ps
// Piecewise affine warp: loads fan polygon pairs into up to 64 stored triangle pairs,
// transforms map a point through the first source triangle strictly containing it.
// A transform scans the stored triangles in load order (memory read, differences,
// products, cross sums, test) and, when a triangle is hit, runs the two bit-serial
// divisions and then the blend (products, sums, add) into the destination triangle.
module triangle_fan_piecewise_affine_warp
   import tfpaw_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_command,
   input  logic               req_polygon_start,
   input  logic signed [31:0] req_src_x,
   input  logic signed [31:0] req_src_y,
   input  logic signed [31:0] req_dst_x,
   input  logic signed [31:0] req_dst_y,
   input  logic signed [31:0] req_point_x,
   input  logic signed [31:0] req_point_y,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_out_x,
   output logic signed [31:0] rsp_out_y,
   output logic [1:0]         rsp_status,
   output logic [5:0]         rsp_triangle_hit
);

   logic    f_valid, f_stall, b_valid, b_stall;
   job_type f_job, b_job;

   tfpaw_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_command, .req_polygon_start,
      .req_src_x, .req_src_y, .req_dst_x, .req_dst_y, .req_point_x, .req_point_y,
      .job_valid(f_valid), .job_stall(f_stall), .job(f_job)
   );

   tfpaw_queue u_queue (
      .clock, .reset, .in_valid(f_valid), .in_stall(f_stall), .in_job(f_job),
      .out_valid(b_valid), .out_stall(b_stall), .out_job(b_job)
   );

   tfpaw_back u_back (
      .clock, .reset, .job_valid(b_valid), .job_stall(b_stall), .job(b_job),
      .rsp_valid, .rsp_stall, .rsp_out_x, .rsp_out_y, .rsp_status, .rsp_triangle_hit
   );

`ifndef SYNTHESIS
   // A hit index is reported only with a mapped point.
   a_hit_only_mapped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_MAPPED |-> rsp_triangle_hit == '0)
      else $error("hit index set without a mapped point");

   // Loads return a zero point.
   a_load_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_LOADED || rsp_status == STATUS_FULL)
      |-> rsp_out_x == 32'sd0 && rsp_out_y == 32'sd0)
      else $error("load result carries a nonzero point");

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status))
      else $error("stalled result changed");
`endif

endmodule

/* verif/tb_triangle_fan_piecewise_affine_warp.sv */
`timescale 1ns / 1ps
module tb_triangle_fan_piecewise_affine_warp;
   import tfpaw_pkg::*;

   typedef struct {
      logic               command;
      logic               polygon_start;
      logic signed [31:0] src_x, src_y, dst_x, dst_y, point_x, point_y;
   } warp_item_type;

   typedef struct {
      logic signed [31:0] out_x, out_y;
      logic [1:0]         status;
      logic [5:0]         triangle_hit;
   } warp_result_type;

   typedef struct {
      longint x, y;
   } vertex_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_command = CMD_LOAD;
   logic               req_polygon_start = 1'b0;
   logic signed [31:0] req_src_x = '0, req_src_y = '0, req_dst_x = '0, req_dst_y = '0;
   logic signed [31:0] req_point_x = '0, req_point_y = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_out_x, rsp_out_y;
   logic [1:0]         rsp_status;
   logic [5:0]         rsp_triangle_hit;

   // Warp state as seen by the predictor.
   vertex_type   anchor_src, anchor_dst, prev_src, prev_dst;
   int           fan_vertices = 0;
   int           stored_triangles = 0;
   vertex_type   src_fan[MAX_TRIANGLES][3];
   vertex_type   dst_fan[MAX_TRIANGLES][3];

   warp_result_type pending_results[$];
   int           error_count = 0;
   bit           steady_flow = 1'b0;

   triangle_fan_piecewise_affine_warp dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #40ms;
      $display("tb_triangle_fan_piecewise_affine_warp: FAIL");
      $finish;
   end

   // Exact doubled-area cross product ux*vy - uy*vx.
   function automatic logic signed [127:0] cross_area(longint ux, longint uy,
                                                      longint vx, longint vy);
      logic signed [127:0] p, q;
      p = ux;
      q = uy;
      return p * vy - q * vx;
   endfunction

   function automatic logic signed [31:0] blend_coord(longint a, longint b, longint c,
                                                      longint s, longint t);
      longint sum, r;
      sum = (b - a) * s + (c - a) * t;
      r = a + (sum >>> FRACTION_BITS);
      if (r > 64'sd2147483647) r = 64'sd2147483647;
      if (r < -64'sd2147483648) r = -64'sd2147483648;
      return r[31:0];
   endfunction

   // Advance the fan state for one item and return the result it must produce.
   function automatic warp_result_type warp_predict(warp_item_type it);
      warp_result_type     r;
      vertex_type          sv, dv;
      longint              px, py, d1x, d1y, d2x, d2y, vx, vy, s, t;
      logic signed [127:0] den, ns, nt;
      r = '{default: '0};
      if (it.command == CMD_LOAD) begin
         sv = '{it.src_x, it.src_y};
         dv = '{it.dst_x, it.dst_y};
         r.status = STATUS_LOADED;
         if (it.polygon_start || fan_vertices == 0) begin
            anchor_src = sv;
            anchor_dst = dv;
            fan_vertices = 1;
         end else begin
            if (fan_vertices >= 2) begin
               if (stored_triangles < MAX_TRIANGLES) begin
                  src_fan[stored_triangles] = '{anchor_src, prev_src, sv};
                  dst_fan[stored_triangles] = '{anchor_dst, prev_dst, dv};
                  stored_triangles++;
               end else begin
                  r.status = STATUS_FULL;
               end
            end
            fan_vertices = 2;
         end
         prev_src = sv;
         prev_dst = dv;
      end else begin
         px = it.point_x;
         py = it.point_y;
         r.out_x = it.point_x;
         r.out_y = it.point_y;
         r.status = STATUS_PASSED;
         // First source triangle in load order that strictly holds the point wins.
         for (int i = 0; i < stored_triangles; i++) begin
            d1x = src_fan[i][1].x - src_fan[i][0].x;
            d1y = src_fan[i][1].y - src_fan[i][0].y;
            d2x = src_fan[i][2].x - src_fan[i][0].x;
            d2y = src_fan[i][2].y - src_fan[i][0].y;
            vx = px - src_fan[i][0].x;
            vy = py - src_fan[i][0].y;
            den = cross_area(d2x, d2y, d1x, d1y);
            ns = cross_area(vy, vx, d2y, d2x);
            nt = cross_area(vx, vy, d1x, d1y);
            if (den == 0) continue;
            if (den < 0) begin
               den = -den;
               ns = -ns;
               nt = -nt;
            end
            if (ns <= 0 || nt <= 0 || ns + nt >= den) continue;
            s = 64'((ns <<< FRACTION_BITS) / den);
            t = 64'((nt <<< FRACTION_BITS) / den);
            r.out_x = blend_coord(dst_fan[i][0].x, dst_fan[i][1].x, dst_fan[i][2].x, s, t);
            r.out_y = blend_coord(dst_fan[i][0].y, dst_fan[i][1].y, dst_fan[i][2].y, s, t);
            r.status = STATUS_MAPPED;
            r.triangle_hit = 6'(i);
            break;
         end
      end
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
      error_count++;
   endtask

   // Result side: random stalls, and every transfer checked against the oldest prediction.
   always @(posedge clock) begin
      rsp_stall <= !steady_flow && ($urandom_range(99) < 9);
   end

   always @(negedge clock) begin
      warp_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result, status", rsp_status, 0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_out_x !== want.out_x) report_mismatch("out_x", rsp_out_x, want.out_x);
            if (rsp_out_y !== want.out_y) report_mismatch("out_y", rsp_out_y, want.out_y);
            if (rsp_status !== want.status)
               report_mismatch("status", rsp_status, want.status);
            if (rsp_triangle_hit !== want.triangle_hit)
               report_mismatch("triangle_hit", rsp_triangle_hit, want.triangle_hit);
         end
      end
   end

   // Drive one item and hold it until its transfer, then maybe idle a while.
   task automatic send_item(warp_item_type it);
      bit stalled;
      req_valid <= 1'b1;
      req_command <= it.command;
      req_polygon_start <= it.polygon_start;
      req_src_x <= it.src_x;
      req_src_y <= it.src_y;
      req_dst_x <= it.dst_x;
      req_dst_y <= it.dst_y;
      req_point_x <= it.point_x;
      req_point_y <= it.point_y;
      do begin
         @(negedge clock);
         stalled = req_stall;
         @(posedge clock);
      end while (stalled);
      pending_results = {pending_results, warp_predict(it)};
      if (!steady_flow && $urandom_range(99) < 9) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(6, 1)) @(posedge clock);
      end
   endtask

   function automatic logic signed [31:0] random_coord();
      if ($urandom_range(9) == 0) return $urandom;
      return $signed(32'($urandom_range(2 * 2 ** 20))) - 2 ** 20;
   endfunction

   function automatic warp_item_type load_item(bit start, longint sx, longint sy,
                                               longint dx, longint dy);
      return '{CMD_LOAD, start, sx[31:0], sy[31:0], dx[31:0], dy[31:0], $urandom, $urandom};
   endfunction

   function automatic warp_item_type point_item(longint px, longint py);
      return '{CMD_TRANSFORM, 1'($urandom), $urandom, $urandom, $urandom, $urandom,
               px[31:0], py[31:0]};
   endfunction

   task automatic wait_until_drained();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // An empty store passes every point through, extremes included.
   task automatic test_empty_store();
      send_item(point_item(-64'sd2147483648, 64'sd2147483647));
      send_item(point_item(64'sd2147483647, -64'sd2147483648));
      send_item(point_item(0, 0));
   endtask

   // A fan may begin without the start flag right after reset.
   task automatic test_unflagged_first_vertex();
      send_item(load_item(1'b0, 0, 0, 64'sd100 <<< 16, 64'sd100 <<< 16));
      send_item(load_item(1'b0, 64'sd40 <<< 16, 0, 64'sd180 <<< 16, 64'sd90 <<< 16));
      send_item(load_item(1'b0, 0, 64'sd40 <<< 16, 64'sd110 <<< 16, 64'sd170 <<< 16));
      send_item(point_item(64'sd10 <<< 16, 64'sd10 <<< 16));
      send_item(point_item(64'sd13 <<< 16, 64'sd7 <<< 16));
   endtask

   // Points on an edge or a corner are outside.
   task automatic test_boundary();
      send_item(point_item(64'sd20 <<< 16, 0));
      send_item(point_item(0, 0));
      send_item(point_item(64'sd20 <<< 16, 64'sd20 <<< 16));
      send_item(point_item(64'sd40 <<< 16, 0));
   endtask

   // Collinear vertices make a zero-area triangle that holds nothing.
   task automatic test_degenerate();
      send_item(load_item(1'b1, -64'sd50 <<< 16, -64'sd50 <<< 16, 0, 0));
      send_item(load_item(1'b0, -64'sd40 <<< 16, -64'sd40 <<< 16, 5, 5));
      send_item(load_item(1'b0, -64'sd30 <<< 16, -64'sd30 <<< 16, 9, 9));
      send_item(point_item(-64'sd45 <<< 16, -64'sd45 <<< 16));
   endtask

   // Full-range vertices exercise the widest products and divisions.
   task automatic test_extreme_triangle();
      send_item(load_item(1'b1, -64'sd2147483648, -64'sd2147483648,
                          64'sd2147483647, 64'sd2147483647));
      send_item(load_item(1'b0, 64'sd2147483647, -64'sd2147483648,
                          -64'sd2147483648, 64'sd2147483647));
      send_item(load_item(1'b0, -64'sd2147483648, 64'sd2147483647,
                          64'sd2147483647, -64'sd2147483648));
      send_item(point_item(-64'sd1000000000, -64'sd1000000000));
      send_item(point_item(1, -1));
   endtask

   // Random fans and points, mostly aimed inside stored triangles; the store fills up.
   task automatic test_random_warp(int count);
      int      sent, n, k;
      longint  px, py;
      bit      drained;
      sent = 0;
      drained = 1'b0;
      while (sent < count) begin
         steady_flow = (sent > count / 3 && sent < count / 2);
         if (!drained && sent >= count / 4) begin
            wait_until_drained();
            drained = 1'b1;
         end
         if ($urandom_range(99) < 30) begin
            n = $urandom_range(6, 2);
            if ($urandom_range(9) == 0)
               send_item(load_item(1'b0, random_coord(), random_coord(),
                                   random_coord(), random_coord()));
            else
               send_item(load_item(1'b1, random_coord(), random_coord(),
                                   random_coord(), random_coord()));
            for (int v = 0; v < n; v++)
               send_item(load_item(1'b0, random_coord(), random_coord(),
                                   random_coord(), random_coord()));
            sent += n + 1;
         end else begin
            if (stored_triangles > 0 && $urandom_range(99) < 70) begin
               k = $urandom_range(stored_triangles - 1);
               px = (src_fan[k][0].x + src_fan[k][1].x + src_fan[k][2].x) / 3;
               py = (src_fan[k][0].y + src_fan[k][1].y + src_fan[k][2].y) / 3;
               px += $signed(32'($urandom_range(64))) - 32;
               py += $signed(32'($urandom_range(64))) - 32;
               send_item(point_item(px, py));
            end else begin
               send_item(point_item(random_coord(), random_coord()));
            end
            sent++;
         end
      end
      steady_flow = 1'b0;
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_store();
      test_unflagged_first_vertex();
      test_boundary();
      test_degenerate();
      test_extreme_triangle();
      test_random_warp(1130);
      wait_until_drained();
      repeat (500) @(posedge clock);
      if (error_count == 0)
         $display("tb_triangle_fan_piecewise_affine_warp: PASS");
      else
         $display("tb_triangle_fan_piecewise_affine_warp: FAIL");
      $finish;
   end

endmodule

/* triangle_fan_piecewise_affine_warp.f */
design/tfpaw_pkg.sv
design/tfpaw_front.sv
design/tfpaw_queue.sv
design/tfpaw_back.sv
design/triangle_fan_piecewise_affine_warp.sv
verif/tb_triangle_fan_piecewise_affine_warp.sv
